// ----- hdl/mcas_pkg.sv -----
// shared types and constants of the min-cost assignment solver
package mcas_pkg;

   // index fields of a column record (rows and columns up to 127)
   localparam int IDX_W = 7;
   // potentials and slack
   localparam int VAL_W = 48;
   // cost entry and total widths
   localparam int COST_W  = 32;
   localparam int TOTAL_W = 38;

   // largest slack value, also the starting value of a phase
   localparam logic signed [VAL_W-1:0] SLACK_MAX = 48'sh7FFF_FFFF_FFFF;

   // one entry of the column store
   typedef struct packed {
      logic signed [VAL_W-1:0] col_pot;
      logic signed [VAL_W-1:0] slack;
      logic [IDX_W-1:0]        back;
      logic [IDX_W-1:0]        owner;
      logic                    visited;
   } col_rec_type;

endpackage

// ----- hdl/mcas_ram.sv -----
// generic simple dual-port ram with registered read
module mcas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/min_cost_assignment_solver.sv -----
// Minimum-cost assignment solver (Hungarian method, potential form). Cost entries arrive one item
// per cycle in row-major order and go to a cost ram; after n*n entries the block runs the
// shortest-augmenting-path search with the column records (potential, slack, back link, owner,
// visited) in one ram and the row potentials in another, then sends one item per column with the
// assigned row and the total cost, tlast on column n. The solve first clears the column and row
// stores; each phase starts with an init pass, and every search step scans the columns and then
// shifts the potentials, one column per cycle through the scan and the potential update; phase i
// takes at most i steps plus the walk along the augmenting links. The total is then summed, and
// each result item is held until it is accepted before the next one is read. No cost entry is
// accepted from then until the last result item is taken.
module min_cost_assignment_solver #(
   parameter int MAX_SIZE = 32
) (
   input  logic        clock,
   input  logic        reset,
   // cost entries: tdata = cost[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // results: tdata = column[6:0], assigned_row[13:7], total_cost[51:14], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   // matrix_size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);
   import mcas_pkg::*;

   localparam int SW    = $clog2(MAX_SIZE + 1);
   localparam int JW    = $clog2(MAX_SIZE + 2);
   localparam int NSQ   = MAX_SIZE * MAX_SIZE;
   localparam int CAW   = (NSQ > 1) ? $clog2(NSQ) : 1;
   localparam int NSLOT = MAX_SIZE + 1;
   localparam int RED_W = VAL_W + 2;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_PH   = 4'd2;
   localparam logic [3:0] S_ARD  = 4'd3;
   localparam logic [3:0] S_ADAT = 4'd4;
   localparam logic [3:0] S_AROW = 4'd5;
   localparam logic [3:0] S_SCAN = 4'd6;
   localparam logic [3:0] S_UPD  = 4'd7;
   localparam logic [3:0] S_GRD  = 4'd8;
   localparam logic [3:0] S_GDAT = 4'd9;
   localparam logic [3:0] S_TOT  = 4'd10;
   localparam logic [3:0] S_ERD  = 4'd11;
   localparam logic [3:0] S_EDAT = 4'd12;
   localparam logic [3:0] S_EWT  = 4'd13;

   logic [3:0]                state_ff, state_in;
   logic [SW-1:0]             n_ff, n_in;
   logic [CAW-1:0]            last_idx_ff, last_idx_in;
   logic [CAW-1:0]            load_ff, load_in;
   logic [JW-1:0]             i_ff, i_in;
   logic [JW-1:0]             j_ff, j_in;
   logic [SW-1:0]             cur_ff, cur_in;
   logic [SW-1:0]             nxt_ff, nxt_in;
   logic signed [VAL_W-1:0]   delta_ff, delta_in;
   logic signed [VAL_W-1:0]   u_ff, u_in;
   logic [CAW-1:0]            base_ff, base_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic                      pend1_ff, pend1_in;
   logic [JW-1:0]             pj1_ff, pj1_in;
   logic                      pend2_ff, pend2_in;
   logic [SW-1:0]             prow2_ff, prow2_in;
   col_rec_type               cur_rec_ff, cur_rec_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [6:0]                rsp_col_ff, rsp_col_in;
   logic [6:0]                rsp_row_ff, rsp_row_in;
   logic                      rsp_last_ff, rsp_last_in;

   // ram ports
   logic                    col_we;
   logic [SW-1:0]           col_wa, col_ra;
   col_rec_type             col_wd, col_rd;
   logic                    row_we;
   logic [SW-1:0]           row_wa, row_ra;
   logic signed [VAL_W-1:0] row_wd, row_rd;
   logic                    cost_we;
   logic [CAW-1:0]          cost_ra;
   logic signed [COST_W-1:0] cost_rd;

   logic                    req_acc, csr_acc, rsp_acc;
   logic                    issue;
   logic [SW-1:0]           eff_n;
   col_rec_type             rec;
   logic signed [RED_W-1:0] red;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign csr_acc    = csr_valid & csr_ready;
   assign rsp_acc    = rsp_valid_ff & rsp_tready;
   assign cost_we    = req_acc;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, total_ff, rsp_row_ff, rsp_col_ff};

   // clamp of the written size
   always_comb begin
      priority if (csr_data == 7'd0) begin
         eff_n = SW'(1);
      end else if (int'(csr_data) > MAX_SIZE) begin
         eff_n = SW'(MAX_SIZE);
      end else begin
         eff_n = SW'(csr_data);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      last_idx_in  = last_idx_ff;
      load_in      = load_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      delta_in     = delta_ff;
      u_in         = u_ff;
      base_in      = base_ff;
      total_in     = total_ff;
      pend1_in     = 1'b0;
      pj1_in       = j_ff;
      pend2_in     = 1'b0;
      prow2_in     = prow2_ff;
      cur_rec_in   = cur_rec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      col_we       = 1'b0;
      col_wa       = pj1_ff[SW-1:0];
      col_wd       = col_rd;
      col_ra       = j_ff[SW-1:0];
      row_we       = 1'b0;
      row_wa       = prow2_ff;
      row_wd       = row_rd + delta_ff;
      row_ra       = SW'(col_rd.owner);
      cost_ra      = base_ff + CAW'(j_ff) - CAW'(1);
      issue        = (j_ff <= JW'(n_ff));
      rec          = col_rd;
      red          = RED_W'(cost_rd) - RED_W'(u_ff) - RED_W'(col_rd.col_pot);

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (load_ff == last_idx_ff) begin
                  load_in  = '0;
                  j_in     = '0;
                  state_in = S_CLR;
               end else begin
                  load_in = load_ff + CAW'(1);
               end
            end
            if (csr_acc) begin
               n_in        = eff_n;
               last_idx_in = CAW'(int'(eff_n) * int'(eff_n) - 1);
               load_in     = '0;
            end
         end

         // zero the column and row stores for the run
         S_CLR: begin
            col_we = 1'b1;
            col_wa = j_ff[SW-1:0];
            col_wd = '0;
            row_we = 1'b1;
            row_wa = j_ff[SW-1:0];
            row_wd = '0;
            if (j_ff == JW'(n_ff)) begin
               j_in     = '0;
               i_in     = JW'(1);
               state_in = S_PH;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end

         // phase init: slack to max, visited off, slot 0 owned by row i
         S_PH: begin
            pend1_in = issue;
            if (issue) begin
               j_in = j_ff + JW'(1);
            end
            if (pend1_ff) begin
               rec.slack   = SLACK_MAX;
               rec.visited = 1'b0;
               if (pj1_ff == '0) begin
                  rec.owner = IDX_W'(i_ff);
               end
               col_we = 1'b1;
               col_wd = rec;
            end
            if (!issue && !pend1_ff) begin
               cur_in   = '0;
               state_in = S_ARD;
            end
         end

         S_ARD: begin
            col_ra   = cur_ff;
            state_in = S_ADAT;
         end

         // free column reached or mark visited and fetch its row potential
         S_ADAT: begin
            if (col_rd.owner == '0) begin
               cur_rec_in = col_rd;
               state_in   = S_GRD;
            end else begin
               rec.visited = 1'b1;
               col_we      = 1'b1;
               col_wa      = cur_ff;
               col_wd      = rec;
               base_in     = CAW'((int'(col_rd.owner) - 1) * int'(n_ff));
               state_in    = S_AROW;
            end
         end

         S_AROW: begin
            u_in     = row_rd;
            delta_in = SLACK_MAX;
            nxt_in   = '0;
            j_in     = JW'(1);
            state_in = S_SCAN;
         end

         // scan unvisited columns, relax slack, track the minimum
         S_SCAN: begin
            pend1_in = issue;
            if (issue) begin
               j_in = j_ff + JW'(1);
            end
            if (pend1_ff) begin
               if (!col_rd.visited) begin
                  if (red < RED_W'(col_rd.slack)) begin
                     rec.slack = VAL_W'(red);
                     rec.back  = IDX_W'(cur_ff);
                  end
                  if (rec.slack < delta_ff) begin
                     delta_in = rec.slack;
                     nxt_in   = pj1_ff[SW-1:0];
                  end
                  col_we = 1'b1;
                  col_wd = rec;
               end
            end
            if (!issue && !pend1_ff) begin
               j_in     = '0;
               state_in = S_UPD;
            end
         end

         // shift potentials and slack by the minimum
         S_UPD: begin
            pend1_in = issue;
            if (issue) begin
               j_in = j_ff + JW'(1);
            end
            if (pend1_ff) begin
               if (col_rd.visited) begin
                  rec.col_pot = col_rd.col_pot - delta_ff;
                  pend2_in    = 1'b1;
                  prow2_in    = SW'(col_rd.owner);
               end else begin
                  rec.slack = col_rd.slack - delta_ff;
               end
               col_we = 1'b1;
               col_wd = rec;
            end
            if (pend2_ff) begin
               row_we = 1'b1;
            end
            if (!issue && !pend1_ff && !pend2_ff) begin
               cur_in   = nxt_ff;
               state_in = S_ARD;
            end
         end

         // walk the back links and shift owners along the path
         S_GRD: begin
            col_ra   = SW'(cur_rec_ff.back);
            state_in = S_GDAT;
         end

         S_GDAT: begin
            rec       = cur_rec_ff;
            rec.owner = col_rd.owner;
            col_we    = 1'b1;
            col_wa    = cur_ff;
            col_wd    = rec;
            cur_in    = SW'(cur_rec_ff.back);
            cur_rec_in = col_rd;
            if (cur_rec_ff.back == '0) begin
               if (i_ff == JW'(n_ff)) begin
                  j_in     = JW'(1);
                  total_in = '0;
                  state_in = S_TOT;
               end else begin
                  i_in     = i_ff + JW'(1);
                  j_in     = '0;
                  state_in = S_PH;
               end
            end else begin
               state_in = S_GRD;
            end
         end

         // sum the chosen costs
         S_TOT: begin
            pend1_in = issue;
            if (issue) begin
               j_in = j_ff + JW'(1);
            end
            cost_ra = CAW'((int'(col_rd.owner) - 1) * int'(n_ff) + int'(pj1_ff) - 1);
            pend2_in = pend1_ff;
            if (pend2_ff) begin
               total_in = total_ff + TOTAL_W'(cost_rd);
            end
            if (!issue && !pend1_ff && !pend2_ff) begin
               j_in     = JW'(1);
               state_in = S_ERD;
            end
         end

         // one result item per column
         S_ERD: begin
            state_in = S_EDAT;
         end

         S_EDAT: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = 7'(j_ff);
            rsp_row_in   = 7'(col_rd.owner);
            rsp_last_in  = (j_ff == JW'(n_ff));
            state_in     = S_EWT;
         end

         S_EWT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + JW'(1);
                  state_in = S_ERD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= SW'(1);
         last_idx_ff  <= '0;
         load_ff      <= '0;
         pend1_ff     <= 1'b0;
         pend2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         last_idx_ff  <= last_idx_in;
         load_ff      <= load_in;
         pend1_ff     <= pend1_in;
         pend2_ff     <= pend2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      delta_ff    <= delta_in;
      u_ff        <= u_in;
      base_ff     <= base_in;
      total_ff    <= total_in;
      pj1_ff      <= pj1_in;
      prow2_ff    <= prow2_in;
      cur_rec_ff  <= cur_rec_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   // cost matrix store
   mcas_ram #(
      .WIDTH (COST_W),
      .DEPTH (NSQ)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (load_ff),
      .wr_data (req_tdata),
      .rd_addr (cost_ra),
      .rd_data (cost_rd)
   );

   // column records
   mcas_ram #(
      .WIDTH ($bits(col_rec_type)),
      .DEPTH (NSLOT)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_wa),
      .wr_data (col_wd),
      .rd_addr (col_ra),
      .rd_data (col_rd)
   );

   // row potentials
   mcas_ram #(
      .WIDTH (VAL_W),
      .DEPTH (NSLOT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_wa),
      .wr_data (row_wd),
      .rd_addr (row_ra),
      .rd_data (row_rd)
   );

endmodule

// ----- tb/min_cost_assignment_solver_test.sv -----
// testbench of the min-cost assignment solver: random cost matrices checked against a predictor
`timescale 1ns / 100ps

module min_cost_assignment_solver_test;
   import mcas_pkg::*;

   localparam int MAX_N      = 32;
   localparam int STORE_D    = MAX_N * MAX_N;
   localparam int IDLE_LIMIT = 400000;
   localparam int SETTLE     = 60;
   localparam int ITEMS      = 120;

   // fill kinds of a cost matrix
   localparam int FILL_FULL    = 0;
   localparam int FILL_NARROW  = 1;
   localparam int FILL_TIES    = 2;
   localparam int FILL_EXTREME = 3;

   typedef struct {
      logic [IDX_W-1:0]   column;
      logic [IDX_W-1:0]   assigned_row;
      logic [TOTAL_W-1:0] total_cost;
      logic               last;
   } column_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [6:0]  csr_data;

   // predictor state
   int                size_reg;
   int                loaded;
   int                cost_mem [0:STORE_D-1];
   column_result_type expected_cols[$];
   logic [31:0]       pending_costs[$];

   int  mismatches;
   int  queued;
   int  req_gap;
   int  rsp_stall;
   bit  no_idle;
   int  idle_cycles;

   min_cost_assignment_solver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int draw_wait();
      if (no_idle) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic int active_size();
      if (size_reg < 1) return 1;
      if (size_reg > MAX_N) return MAX_N;
      return size_reg;
   endfunction

   function automatic longint cost_at(int n, int r, int c);
      int idx;
      idx = (r - 1) * n + (c - 1);
      if (r < 1 || c < 1 || idx >= STORE_D) return 0;
      return longint'(cost_mem[idx]);
   endfunction

   // shortest augmenting path with row and column potentials, then one result per column
   task automatic solve_assignment(input int n);
      longint            row_pot [0:MAX_N];
      longint            col_pot [0:MAX_N];
      longint            slack   [0:MAX_N];
      int                owner   [0:MAX_N];
      int                back    [0:MAX_N];
      bit                seen    [0:MAX_N];
      longint            slack_top;
      longint            delta;
      longint            red;
      longint            total;
      int                cur;
      int                nxt;
      int                r;
      int                prev;
      column_result_type res;
      slack_top = longint'(SLACK_MAX);
      for (int j = 0; j <= MAX_N; j++) begin
         row_pot[j] = 0;
         col_pot[j] = 0;
         owner[j]   = 0;
         back[j]    = 0;
      end
      for (int i = 1; i <= n; i++) begin
         cur = 0;
         for (int j = 0; j <= n; j++) begin
            slack[j] = slack_top;
            seen[j]  = 1'b0;
         end
         owner[0] = i;
         do begin
            r     = owner[cur];
            delta = slack_top;
            nxt   = 0;
            seen[cur] = 1'b1;
            for (int j = 1; j <= n; j++) begin
               if (!seen[j]) begin
                  red = cost_at(n, r, j) - row_pot[r] - col_pot[j];
                  if (red < slack[j]) begin
                     slack[j] = red;
                     back[j]  = cur;
                  end
                  if (slack[j] < delta) begin
                     delta = slack[j];
                     nxt   = j;
                  end
               end
            end
            for (int j = 0; j <= n; j++) begin
               if (seen[j]) begin
                  row_pot[owner[j]] += delta;
                  col_pot[j]        -= delta;
               end else begin
                  slack[j] -= delta;
               end
            end
            cur = nxt;
         end while (owner[cur] != 0);
         // flip the augmenting path
         do begin
            prev       = back[cur];
            owner[cur] = owner[prev];
            cur        = prev;
         end while (cur != 0);
      end
      total = 0;
      for (int j = 1; j <= n; j++) total += cost_at(n, owner[j], j);
      for (int j = 1; j <= n; j++) begin
         res.column       = j[IDX_W-1:0];
         res.assigned_row = owner[j][IDX_W-1:0];
         res.total_cost   = total[TOTAL_W-1:0];
         res.last         = (j == n);
         expected_cols    = {expected_cols, res};
      end
   endtask

   // store one accepted cost entry; the last entry of the matrix triggers the solve
   task automatic take_cost(input logic [31:0] value);
      int n;
      n = active_size();
      if (loaded < STORE_D) cost_mem[loaded] = $signed(value);
      loaded++;
      if (loaded >= n * n) begin
         loaded = 0;
         solve_assignment(n);
      end
   endtask

   // cost item driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_costs.size() > 0) begin
            req_tdata  <= pending_costs.pop_front();
            req_tvalid <= 1'b1;
            req_gap    <= draw_wait();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predictor follows accepted cost items
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) take_cost(req_tdata);
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      column_result_type want;
      int                stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_cols.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_cols.pop_front();
            if (rsp_tdata[6:0] !== want.column || rsp_tdata[13:7] !== want.assigned_row ||
                rsp_tdata[51:14] !== want.total_cost || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected col %0d row %0d total %0d last %b,",
                            " got col %0d row %0d total %0d last %b"},
                           want.column, want.assigned_row, $signed(want.total_cost), want.last,
                           rsp_tdata[6:0], rsp_tdata[13:7], $signed(rsp_tdata[51:14]),
                           rsp_tlast);
            end
         end
         stall = draw_wait();
         rsp_stall  <= stall;
         rsp_tready <= (stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** min_cost_assignment_solver: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // block until every queued item is accepted and every result has arrived
   task automatic wait_drained();
      while (pending_costs.size() > 0 || req_tvalid || expected_cols.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(input logic [6:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = value;
      loaded   = 0;
   endtask

   // queue cost items of one fill kind
   task automatic queue_costs(input int count, input int kind);
      logic [31:0] c;
      for (int k = 0; k < count; k++) begin
         case (kind)
            FILL_FULL:   c = $urandom;
            FILL_NARROW: c = 32'($urandom_range(0, 40)) - 32'd20;
            FILL_TIES:   c = 32'd7;
            default:     c = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         endcase
         pending_costs = {pending_costs, c};
         queued++;
      end
   endtask

   task automatic run_matrix(input logic [6:0] size_val, input int kind);
      int n;
      wait_drained();
      no_idle = ($urandom_range(0, 3) == 0);
      write_size(size_val);
      n = active_size();
      queue_costs(n * n, kind);
   endtask

   initial begin
      int n;
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_data    = '0;
      mismatches  = 0;
      queued      = 0;
      no_idle     = 1'b0;
      idle_cycles = 0;
      size_reg    = 1;
      loaded      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one-entry matrices with the default size, then extreme values
      pending_costs = {pending_costs, 32'h7FFF_FFFF, 32'h8000_0000};
      queued += 2;
      // size zero behaves as one
      run_matrix(7'd0, FILL_FULL);
      run_matrix(7'd2, FILL_EXTREME);
      run_matrix(7'd3, FILL_TIES);
      // a size write drops a half-loaded matrix
      run_matrix(7'd3, FILL_FULL);
      wait_drained();
      pending_costs.delete();
      write_size(7'd3);
      queue_costs(4, FILL_FULL);
      wait_drained();
      write_size(7'd2);
      queue_costs(4, FILL_NARROW);

      // random matrices, mostly small
      while (queued < ITEMS) begin
         n = $urandom_range(1, 8);
         while (n * n > ITEMS - queued) n--;
         run_matrix(7'(n), $urandom_range(FILL_FULL, FILL_EXTREME));
      end

      wait_drained();
      if (mismatches == 0 && expected_cols.size() == 0) begin
         $display("** min_cost_assignment_solver: PASSED **");
      end else begin
         $display("** min_cost_assignment_solver: FAILED **");
      end
      $finish;
   end

endmodule
